/* design/mti_pkg.sv */
// Shared types and constants of the monotone table interpolator.
`default_nettype none

package mti_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 11;
  localparam int KIND_W      = 2;
  localparam int DIV_CNT_W   = $clog2(FRAC_BITS);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_V2R  = 2'd1,
    KIND_R2V  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_MID,
    RD_IDX,
    RD_IDX_NEXT
  } rd_sel_e;

  typedef enum logic [2:0] {
    RES_ZERO_RANK,
    RES_LAST_RANK,
    RES_QUOTIENT,
    RES_READ,
    RES_INTERP
  } res_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V_FIRST,
    ST_V_LAST,
    ST_V_SEARCH,
    ST_V_COMPARE,
    ST_V_DIVIDE,
    ST_V_FINISH,
    ST_R_CHECK,
    ST_R_READ_A,
    ST_R_READ_B,
    ST_R_MULTIPLY,
    ST_R_FINISH,
    ST_R_CLAMP
  } state_e;

  typedef struct packed {
    logic     capture;
    logic     mem_we;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     lo_ld;
    logic     srch_init;
    logic     srch_step;
    logic     div_init;
    logic     div_step;
    logic     diff_ld;
    logic     mul_ld;
    logic     res_ld;
    res_sel_e res_sel;
    logic     res_clamp;
  } dp_cmd_t;

  typedef struct packed {
    logic v_le_rd;
    logic v_ge_rd;
    logic search_more;
    logic div_last;
    logic r_le_zero;
    logic r_ge_top;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/monotone_table_interpolator.sv */
// Top level of the monotone table interpolator: controller plus datapath.
// A load transaction (kind 0) writes one table entry at the accepting edge and leaves busy
// low, so loads can be issued every cycle. Queries raise busy until the result is shown;
// the result sits on the result ports for exactly one cycle with result_valid_o high, and
// busy is already low in that cycle, so the next transaction can start alongside it.
// A value-to-rank query compares the value with the first and the last entry, then runs
// a binary search of about ceil(log2(count-1)) steps (10 for a full table): every search
// step takes one read of the single-port table plus a compare, and the fractional rank
// comes from a restoring divider that retires one quotient bit per cycle.
// Low-end clamps answer after the first compare, high-end clamps after the second.
// A rank-to-value query takes two table reads, a subtract, one multiply and an add, or
// a single table read when it clamps. Kind 3 is ignored. The table is not cleared by
// reset: query only entries that were loaded.
`default_nettype none

module monotone_table_interpolator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [mti_pkg::KIND_W-1:0]          kind_i,
  input  wire logic [mti_pkg::ADDR_W-1:0]          entry_index_i,
  input  wire logic signed [mti_pkg::DATA_W-1:0]   value_i,
  input  wire logic                                entry_count_we_i,
  input  wire logic [mti_pkg::COUNT_W-1:0]         entry_count_i,
  output logic                                     result_valid_o,
  output logic signed [mti_pkg::DATA_W-1:0]        result_value_o,
  output logic                                     clamped_o,
  output logic [mti_pkg::KIND_W-1:0]               answered_kind_o
);

  mti_pkg::dp_cmd_t    cmd;
  mti_pkg::dp_status_t status;

  mti_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  mti_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .kind_i           (kind_i),
    .entry_index_i    (entry_index_i),
    .value_i          (value_i),
    .entry_count_we_i (entry_count_we_i),
    .entry_count_i    (entry_count_i),
    .result_valid_o   (result_valid_o),
    .result_value_o   (result_value_o),
    .clamped_o        (clamped_o),
    .answered_kind_o  (answered_kind_o)
  );

endmodule

`default_nettype wire

/* design/mti_ctrl.sv */
// Controller state machine that sequences table reads, search, divide and interpolation.
`default_nettype none

module mti_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [mti_pkg::KIND_W-1:0]     kind_i,
  input  wire mti_pkg::dp_status_t            status_i,
  output mti_pkg::dp_cmd_t                    cmd_o,
  output logic                                busy_o
);

  mti_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mti_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mti_pkg::ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            mti_pkg::KIND_V2R: state_d = mti_pkg::ST_V_FIRST;
            mti_pkg::KIND_R2V: state_d = mti_pkg::ST_R_CHECK;
            default:           state_d = mti_pkg::ST_IDLE;
          endcase
        end
      end
      mti_pkg::ST_V_FIRST: begin
        state_d = status_i.v_le_rd ? mti_pkg::ST_IDLE : mti_pkg::ST_V_LAST;
      end
      mti_pkg::ST_V_LAST: begin
        state_d = status_i.v_ge_rd ? mti_pkg::ST_IDLE : mti_pkg::ST_V_SEARCH;
      end
      mti_pkg::ST_V_SEARCH: begin
        state_d = status_i.search_more ? mti_pkg::ST_V_COMPARE : mti_pkg::ST_V_DIVIDE;
      end
      mti_pkg::ST_V_COMPARE: state_d = mti_pkg::ST_V_SEARCH;
      mti_pkg::ST_V_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = mti_pkg::ST_V_FINISH;
        end
      end
      mti_pkg::ST_V_FINISH: state_d = mti_pkg::ST_IDLE;
      mti_pkg::ST_R_CHECK: begin
        if (status_i.r_le_zero || status_i.r_ge_top) begin
          state_d = mti_pkg::ST_R_CLAMP;
        end else begin
          state_d = mti_pkg::ST_R_READ_A;
        end
      end
      mti_pkg::ST_R_READ_A:   state_d = mti_pkg::ST_R_READ_B;
      mti_pkg::ST_R_READ_B:   state_d = mti_pkg::ST_R_MULTIPLY;
      mti_pkg::ST_R_MULTIPLY: state_d = mti_pkg::ST_R_FINISH;
      mti_pkg::ST_R_FINISH:   state_d = mti_pkg::ST_IDLE;
      mti_pkg::ST_R_CLAMP:    state_d = mti_pkg::ST_IDLE;
      default:                state_d = mti_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_sel  = mti_pkg::RD_ZERO;
    cmd_o.res_sel = mti_pkg::RES_ZERO_RANK;
    busy_o        = (state_q != mti_pkg::ST_IDLE);
    case (state_q)
      mti_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          case (kind_i)
            mti_pkg::KIND_LOAD: cmd_o.mem_we = 1'b1;
            mti_pkg::KIND_V2R: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = mti_pkg::RD_ZERO;
            end
            default: ;
          endcase
        end
      end
      mti_pkg::ST_V_FIRST: begin
        if (status_i.v_le_rd) begin
          cmd_o.res_ld    = 1'b1;
          cmd_o.res_sel   = mti_pkg::RES_ZERO_RANK;
          cmd_o.res_clamp = 1'b1;
        end else begin
          cmd_o.lo_ld  = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mti_pkg::RD_LAST;
        end
      end
      mti_pkg::ST_V_LAST: begin
        if (status_i.v_ge_rd) begin
          cmd_o.res_ld    = 1'b1;
          cmd_o.res_sel   = mti_pkg::RES_LAST_RANK;
          cmd_o.res_clamp = 1'b1;
        end else begin
          cmd_o.srch_init = 1'b1;
        end
      end
      mti_pkg::ST_V_SEARCH: begin
        if (status_i.search_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mti_pkg::RD_MID;
        end else begin
          cmd_o.div_init = 1'b1;
        end
      end
      mti_pkg::ST_V_COMPARE: cmd_o.srch_step = 1'b1;
      mti_pkg::ST_V_DIVIDE:  cmd_o.div_step = 1'b1;
      mti_pkg::ST_V_FINISH: begin
        cmd_o.res_ld  = 1'b1;
        cmd_o.res_sel = mti_pkg::RES_QUOTIENT;
      end
      mti_pkg::ST_R_CHECK: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.r_le_zero) begin
          cmd_o.rd_sel = mti_pkg::RD_ZERO;
        end else if (status_i.r_ge_top) begin
          cmd_o.rd_sel = mti_pkg::RD_LAST;
        end else begin
          cmd_o.rd_sel = mti_pkg::RD_IDX;
        end
      end
      mti_pkg::ST_R_READ_A: begin
        cmd_o.lo_ld  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = mti_pkg::RD_IDX_NEXT;
      end
      mti_pkg::ST_R_READ_B:   cmd_o.diff_ld = 1'b1;
      mti_pkg::ST_R_MULTIPLY: cmd_o.mul_ld = 1'b1;
      mti_pkg::ST_R_FINISH: begin
        cmd_o.res_ld  = 1'b1;
        cmd_o.res_sel = mti_pkg::RES_INTERP;
      end
      mti_pkg::ST_R_CLAMP: begin
        cmd_o.res_ld    = 1'b1;
        cmd_o.res_sel   = mti_pkg::RES_READ;
        cmd_o.res_clamp = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/mti_dp.sv */
// Datapath: table memory, search bounds, restoring divider, multiplier and result registers.
`default_nettype none

module mti_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mti_pkg::dp_cmd_t                    cmd_i,
  output mti_pkg::dp_status_t                      status_o,
  input  wire logic [mti_pkg::KIND_W-1:0]          kind_i,
  input  wire logic [mti_pkg::ADDR_W-1:0]          entry_index_i,
  input  wire logic signed [mti_pkg::DATA_W-1:0]   value_i,
  input  wire logic                                entry_count_we_i,
  input  wire logic [mti_pkg::COUNT_W-1:0]         entry_count_i,
  output logic                                     result_valid_o,
  output logic signed [mti_pkg::DATA_W-1:0]        result_value_o,
  output logic                                     clamped_o,
  output logic [mti_pkg::KIND_W-1:0]               answered_kind_o
);

  localparam int DW   = mti_pkg::DATA_W;
  localparam int AW   = mti_pkg::ADDR_W;
  localparam int FB   = mti_pkg::FRAC_BITS;
  localparam int CW   = mti_pkg::COUNT_W;
  localparam int PW   = DW + FB + 2;

  logic [DW-1:0]                mem [mti_pkg::TABLE_DEPTH];
  logic signed [DW-1:0]         rdata_q;
  logic [AW-1:0]                rd_addr;

  logic [CW-1:0]                entry_count_q;
  logic [mti_pkg::KIND_W-1:0]   kind_q;
  logic signed [DW-1:0]         value_q;
  logic [AW-1:0]                lo_q, hi_q;
  logic signed [DW-1:0]         t_lo_q, t_hi_q;
  logic [DW-1:0]                rem_q, gap_q;
  logic [FB-1:0]                quo_q;
  logic [mti_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic signed [DW:0]           diff_q;
  logic signed [PW-1:0]         prod_q;

  logic                         valid_q, clamped_q;
  logic signed [DW-1:0]         result_q;
  logic [mti_pkg::KIND_W-1:0]   answered_q;

  logic [AW-1:0]                last_idx;
  logic [DW-1:0]                top_rank;
  logic [AW:0]                  mid_sum;
  logic [AW-1:0]                mid;
  logic [AW-1:0]                r_idx;
  logic signed [DW:0]           v_minus_lo, hi_minus_lo, rd_minus_lo;
  logic [DW:0]                  rem_sh, rem_sub;
  logic signed [DW-1:0]         interp;
  logic signed [DW-1:0]         res_mux;

  // Entry counts of zero act as one, counts beyond the table act as the full table.
  always_comb begin
    if (entry_count_q == '0) begin
      last_idx = '0;
    end else if (entry_count_q > CW'(mti_pkg::TABLE_DEPTH)) begin
      last_idx = AW'(mti_pkg::TABLE_DEPTH - 1);
    end else begin
      last_idx = AW'(entry_count_q - 1'b1);
    end
  end

  assign top_rank = DW'({last_idx, {FB{1'b0}}});
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[AW:1];
  assign r_idx    = value_q[FB +: AW];

  always_comb begin
    case (cmd_i.rd_sel)
      mti_pkg::RD_ZERO:     rd_addr = '0;
      mti_pkg::RD_LAST:     rd_addr = last_idx;
      mti_pkg::RD_MID:      rd_addr = mid;
      mti_pkg::RD_IDX:      rd_addr = r_idx;
      mti_pkg::RD_IDX_NEXT: rd_addr = r_idx + 1'b1;
      default:              rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[entry_index_i] <= value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign v_minus_lo  = {value_q[DW-1], value_q} - {t_lo_q[DW-1], t_lo_q};
  assign hi_minus_lo = {t_hi_q[DW-1], t_hi_q} - {t_lo_q[DW-1], t_lo_q};
  assign rd_minus_lo = {rdata_q[DW-1], rdata_q} - {t_lo_q[DW-1], t_lo_q};

  // The search keeps t[lo] <= value < t[hi], so the remainder always stays below the gap.
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, gap_q};

  assign interp = t_lo_q + prod_q[FB +: DW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    if (cmd_i.lo_ld) begin
      t_lo_q <= rdata_q;
    end
    if (cmd_i.srch_init) begin
      lo_q   <= '0;
      hi_q   <= last_idx;
      t_hi_q <= rdata_q;
    end
    if (cmd_i.srch_step) begin
      if (value_q < rdata_q) begin
        hi_q   <= mid;
        t_hi_q <= rdata_q;
      end else begin
        lo_q   <= mid;
        t_lo_q <= rdata_q;
      end
    end
    if (cmd_i.div_init) begin
      rem_q     <= v_minus_lo[DW-1:0];
      gap_q     <= hi_minus_lo[DW-1:0];
      quo_q     <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, gap_q}) begin
        rem_q <= rem_sub[DW-1:0];
        quo_q <= {quo_q[FB-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DW-1:0];
        quo_q <= {quo_q[FB-2:0], 1'b0};
      end
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (cmd_i.diff_ld) begin
      diff_q <= rd_minus_lo;
    end
    if (cmd_i.mul_ld) begin
      // The arithmetic shift of the signed product floors toward minus infinity.
      prod_q <= PW'(diff_q * $signed({1'b0, value_q[FB-1:0]}));
    end
  end

  always_comb begin
    case (cmd_i.res_sel)
      mti_pkg::RES_ZERO_RANK: res_mux = '0;
      mti_pkg::RES_LAST_RANK: res_mux = top_rank;
      mti_pkg::RES_QUOTIENT:  res_mux = DW'({lo_q, quo_q});
      mti_pkg::RES_READ:      res_mux = rdata_q;
      mti_pkg::RES_INTERP:    res_mux = interp;
      default:                res_mux = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      result_q   <= res_mux;
      clamped_q  <= cmd_i.res_clamp;
      answered_q <= kind_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= CW'(1);
      valid_q       <= 1'b0;
    end else begin
      if (entry_count_we_i) begin
        entry_count_q <= entry_count_i;
      end
      valid_q <= cmd_i.res_ld;
    end
  end

  assign status_o.v_le_rd     = (value_q <= rdata_q);
  assign status_o.v_ge_rd     = (value_q >= rdata_q);
  assign status_o.search_more = ({1'b0, hi_q} > ({1'b0, lo_q} + 1'b1));
  assign status_o.div_last    = (div_cnt_q == mti_pkg::DIV_CNT_W'(FB - 1));
  assign status_o.r_le_zero   = (value_q <= 0);
  assign status_o.r_ge_top    = (value_q >= $signed(top_rank));

  assign result_valid_o  = valid_q;
  assign result_value_o  = result_q;
  assign clamped_o       = clamped_q;
  assign answered_kind_o = answered_q;

endmodule

`default_nettype wire

/* design/mti_checker.sv */
// Port-level checker for the monotone table interpolator and its bind statement.
`default_nettype none

module mti_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic [mti_pkg::KIND_W-1:0]          kind_i,
  input wire logic                                result_valid_o,
  input wire logic [mti_pkg::KIND_W-1:0]          answered_kind_o
);

  // Every query passes through at least one working state, so results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (answered_kind_o == mti_pkg::KIND_V2R ||
                        answered_kind_o == mti_pkg::KIND_R2V))
    else $error("result answers a transaction kind that gives no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("block still busy while showing its result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == mti_pkg::KIND_LOAD) |=> (!busy && !result_valid_o))
    else $error("load transaction made the block busy or produced a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == mti_pkg::KIND_V2R || kind_i == mti_pkg::KIND_R2V))
      |=> busy)
    else $error("query transaction did not make the block busy");

endmodule

bind monotone_table_interpolator mti_checker u_mti_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the monotone table interpolator: loads, rank and value queries.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mti_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam longint INT_LO = -64'sd2147483648;
  localparam longint INT_HI = 64'sd2147483647;
  localparam longint FRAC_MASK = (64'sd1 << FRAC_BITS) - 1;
  // Leave a wide margin of idle cycles after the last transaction.
  localparam int QUIET_CYCLES = 80;

  typedef enum int {
    SHAPE_ASCEND,
    SHAPE_FLAT,
    SHAPE_SCRAMBLED,
    SHAPE_KEEP
  } table_shape_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [ADDR_W-1:0]        index;
    logic signed [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clamped;
    logic [KIND_W-1:0]        kind;
  } answer_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KIND_W-1:0]        kind_i = '0;
  logic [ADDR_W-1:0]        entry_index_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     entry_count_we_i = 1'b0;
  logic [COUNT_W-1:0]       entry_count_i = '0;
  logic                     result_valid_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic                     clamped_o;
  logic [KIND_W-1:0]        answered_kind_o;

  monotone_table_interpolator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .entry_index_i    (entry_index_i),
    .value_i          (value_i),
    .entry_count_we_i (entry_count_we_i),
    .entry_count_i    (entry_count_i),
    .result_valid_o   (result_valid_o),
    .result_value_o   (result_value_o),
    .clamped_o        (clamped_o),
    .answered_kind_o  (answered_kind_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the block state, updated at every accepted load and entry-count write.
  logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
  logic [COUNT_W-1:0]       shadow_count = 11'd1;

  // Contents the stimulus generator believes the table will hold.
  longint plan_table [TABLE_DEPTH];

  request_t pending_requests[$];
  answer_t  awaited_answers[$];

  int  fault_count = 0;
  int  loads_taken = 0;
  int  ranks_asked = 0;
  int  values_asked = 0;
  int  clamps_predicted = 0;
  int  ignored_taken = 0;
  int  answers_checked = 0;
  int  gap_left = 0;
  int  gap_roll;
  bit  gapless_mode = 1'b0;
  request_t next_req;
  answer_t  want;

  function automatic int unsigned eff_count(logic [COUNT_W-1:0] c);
    if (c < 1) return 1;
    if (c > TABLE_DEPTH) return TABLE_DEPTH;
    return c;
  endfunction

  function automatic longint shadow_entry(int unsigned i);
    return longint'(shadow_table[i]);
  endfunction

  function automatic logic signed [DATA_W-1:0] clip32(longint x);
    if (x > INT_HI) return INT_HI[DATA_W-1:0];
    if (x < INT_LO) return INT_LO[DATA_W-1:0];
    return x[DATA_W-1:0];
  endfunction

  // Fractional rank: clamps at the ends, else binary search for the bracketing pair, floor divide.
  function automatic void rank_of_value(input longint v, output longint rank, output bit clamp);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    longint gap;
    longint num;
    n = eff_count(shadow_count);
    lo = 0;
    hi = n - 1;
    clamp = 1'b1;
    if (v <= shadow_entry(0)) begin
      rank = 0;
    end else if (v >= shadow_entry(n - 1)) begin
      rank = longint'(n - 1) << FRAC_BITS;
    end else begin
      clamp = 1'b0;
      while (hi > lo + 1) begin
        mid = (lo + hi) / 2;
        if (v < shadow_entry(mid)) hi = mid;
        else lo = mid;
      end
      rank = longint'(lo) << FRAC_BITS;
      gap = shadow_entry(hi) - shadow_entry(lo);
      if (gap > 0 && v >= shadow_entry(lo)) begin
        num = (v - shadow_entry(lo)) << FRAC_BITS;
        rank += num / gap;
      end
    end
    if (rank > INT_HI) rank = INT_HI;
  endfunction

  // Table value at a fractional rank; the step is floored for both signs of the slope.
  function automatic void value_at_rank(input longint r, output longint val, output bit clamp);
    int unsigned n;
    int unsigned idx;
    longint top;
    longint f;
    longint base;
    longint delta;
    longint step;
    n = eff_count(shadow_count);
    top = longint'(n - 1) << FRAC_BITS;
    clamp = 1'b1;
    if (r <= 0) begin
      val = shadow_entry(0);
    end else if (r >= top) begin
      val = shadow_entry(n - 1);
    end else begin
      clamp = 1'b0;
      idx = r >> FRAC_BITS;
      f = r & FRAC_MASK;
      base = shadow_entry(idx);
      delta = shadow_entry(idx + 1) - base;
      if (delta >= 0) step = (delta * f) >> FRAC_BITS;
      else step = -((((-delta) * f) + FRAC_MASK) >> FRAC_BITS);
      val = base + step;
    end
  endfunction

  function automatic void apply_transaction(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] idx,
                                            logic signed [DATA_W-1:0] v);
    answer_t ans;
    longint res;
    bit clamp;
    ans.kind = k;
    case (k)
      KIND_LOAD: begin
        shadow_table[idx] = v;
        loads_taken++;
      end
      KIND_V2R: begin
        rank_of_value(longint'(v), res, clamp);
        ans.value = res[DATA_W-1:0];
        ans.clamped = clamp;
        awaited_answers.push_back(ans);
        ranks_asked++;
        clamps_predicted += clamp;
      end
      KIND_R2V: begin
        value_at_rank(longint'(v), res, clamp);
        ans.value = res[DATA_W-1:0];
        ans.clamped = clamp;
        awaited_answers.push_back(ans);
        values_asked++;
        clamps_predicted += clamp;
      end
      default: ignored_taken++;
    endcase
  endfunction

  function automatic void note_fault(string msg);
    if (fault_count < 10) $display("ERROR at %0t: %s", $realtime, msg);
    fault_count++;
  endfunction

  // Driver: presents queued transactions, with a random gap after each one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      kind_i <= '0;
      entry_index_i <= '0;
      value_i <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) apply_transaction(kind_i, entry_index_i, value_i);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req = pending_requests.pop_front();
          kind_i <= next_req.kind;
          entry_index_i <= next_req.index;
          value_i <= next_req.value;
          start <= 1'b1;
          gap_roll = $urandom_range(0, 99);
          if (gapless_mode || gap_roll < 50) gap_left <= 0;
          else if (gap_roll < 88) gap_left <= $urandom_range(1, 3);
          else if (gap_roll < 97) gap_left <= $urandom_range(4, 20);
          else gap_left <= $urandom_range(30, 90);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest predicted answer.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (awaited_answers.size() == 0) begin
        note_fault($sformatf("unexpected result: value %h clamped %0b kind %0d",
                             result_value_o, clamped_o, answered_kind_o));
      end else begin
        want = awaited_answers.pop_front();
        answers_checked++;
        if (result_value_o !== want.value || clamped_o !== want.clamped ||
            answered_kind_o !== want.kind) begin
          note_fault($sformatf({"mismatch: value exp %h got %h, clamped exp %0b got %0b, ",
                                "kind exp %0d got %0d"},
                               want.value, result_value_o, want.clamped, clamped_o,
                               want.kind, answered_kind_o));
        end
      end
    end
  end

  task automatic push_request(logic [KIND_W-1:0] k, int unsigned idx, longint v);
    request_t req;
    req.kind = k;
    req.index = idx[ADDR_W-1:0];
    req.value = clip32(v);
    pending_requests.push_back(req);
  endtask

  task automatic push_load(int unsigned idx, longint v);
    push_request(KIND_LOAD, idx, v);
    plan_table[idx] = longint'(clip32(v));
  endtask

  task automatic wait_for_quiet();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || start || busy || awaited_answers.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_entry_count(logic [COUNT_W-1:0] c);
    @(posedge clk_i);
    entry_count_we_i <= 1'b1;
    entry_count_i <= c;
    shadow_count = c;
    @(posedge clk_i);
    entry_count_we_i <= 1'b0;
  endtask

  // Fills entries 0..n-1 so that every query of the phase reads written entries only.
  task automatic build_table(int unsigned n, table_shape_e shape);
    longint cur;
    longint maxstep;
    longint step;
    int unsigned i;
    int roll;
    cur = INT_LO + longint'($urandom_range(0, 1 << 20));
    if ($urandom_range(0, 3) == 0) cur = INT_LO + longint'($urandom_range(0, 32'h7FFF_FFFF));
    maxstep = (INT_HI - cur) / n;
    if ($urandom_range(0, 1) == 1) maxstep = maxstep >> $urandom_range(0, 20);
    for (i = 0; i < n; i++) begin
      if (shape == SHAPE_SCRAMBLED) begin
        push_load(i, longint'(int'($urandom)));
      end else begin
        push_load(i, cur);
        roll = $urandom_range(0, 99);
        if (roll < ((shape == SHAPE_FLAT) ? 50 : 10)) step = 0;
        else if (roll < 60) step = longint'($urandom_range(1, 16));
        else step = longint'($urandom_range(0, maxstep));
        if (step > maxstep) step = maxstep;
        cur += step;
      end
    end
  endtask

  task automatic run_phase(logic [COUNT_W-1:0] count, table_shape_e shape, int items,
                           bit gapless);
    int unsigned n;
    int unsigned idx;
    int unsigned pick;
    int roll;
    int sub;
    longint v;
    longint lo_v;
    longint hi_v;
    longint span;
    longint top;
    wait_for_quiet();
    write_entry_count(count);
    @(negedge clk_i);
    gapless_mode = gapless;
    n = eff_count(count);
    top = longint'(n - 1) << FRAC_BITS;
    if (shape != SHAPE_KEEP) build_table(n, shape);
    repeat (items) begin
      roll = $urandom_range(0, 99);
      sub = $urandom_range(0, 99);
      idx = $urandom_range(0, TABLE_DEPTH - 1);
      if (roll < 15) begin
        // Loads inside an unscrambled table keep it ordered three times in four; the rest write noise.
        if (idx < n && shape != SHAPE_SCRAMBLED && sub < 75) begin
          lo_v = (idx > 0) ? plan_table[idx - 1] : INT_LO;
          hi_v = (idx < n - 1) ? plan_table[idx + 1] : INT_HI;
          if (hi_v >= lo_v) v = lo_v + longint'($urandom_range(0, hi_v - lo_v));
          else v = plan_table[idx];
        end else begin
          v = longint'(int'($urandom));
        end
        push_load(idx, v);
      end else if (roll < 18) begin
        push_request(KIND_UNUSED, idx, longint'(int'($urandom)));
      end else if (roll < 59) begin
        pick = $urandom_range(0, n - 1);
        if (sub < 10) begin
          v = longint'(int'($urandom));
        end else if (sub < 35 || n == 1) begin
          v = plan_table[pick];
        end else if (sub < 80) begin
          pick = $urandom_range(0, n - 2);
          span = plan_table[pick + 1] - plan_table[pick];
          v = plan_table[pick];
          if (span > 0) v += longint'($urandom_range(0, span));
        end else if (sub < 90) begin
          v = plan_table[($urandom_range(0, 1) == 1) ? 0 : n - 1];
          v += longint'($urandom_range(0, 2)) - 1;
        end else begin
          v = ($urandom_range(0, 1) == 1) ? INT_LO : INT_HI;
        end
        push_request(KIND_V2R, idx, v);
      end else begin
        if (sub < 10) v = longint'(int'($urandom));
        else if (sub < 60) v = longint'($urandom_range(0, top));
        else if (sub < 75) v = longint'($urandom_range(0, n - 1)) << FRAC_BITS;
        else if (sub < 90) v = (($urandom_range(0, 1) == 1) ? 0 : top)
                               + longint'($urandom_range(0, 2)) - 1;
        else v = ($urandom_range(0, 1) == 1) ? INT_LO : INT_HI;
        push_request(KIND_R2V, idx, v);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single entry at reset count: both clamps from every extreme, plus an ignored kind.
    push_load(0, 64'sh1_0000);
    push_request(KIND_V2R, 1023, INT_LO);
    push_request(KIND_V2R, 0, 64'sh1_0000);
    push_request(KIND_V2R, 0, INT_HI);
    push_request(KIND_R2V, 0, 0);
    push_request(KIND_R2V, 1023, INT_HI);
    push_request(KIND_R2V, 0, INT_LO);
    push_request(KIND_UNUSED, 1023, INT_HI);

    // Two entries spanning the full range, then the same pair descending.
    wait_for_quiet();
    write_entry_count(11'd2);
    @(negedge clk_i);
    push_load(0, INT_LO);
    push_load(1, INT_HI);
    push_request(KIND_V2R, 0, 0);
    push_request(KIND_V2R, 0, INT_LO + 1);
    push_request(KIND_R2V, 0, 64'sh8000);
    push_request(KIND_R2V, 0, FRAC_MASK);
    push_request(KIND_R2V, 0, 64'sh1_0000);
    push_request(KIND_R2V, 0, 1);
    push_load(0, INT_HI);
    push_load(1, INT_LO);
    push_request(KIND_R2V, 0, 64'sh8000);
    push_request(KIND_R2V, 0, 1);
    push_request(KIND_V2R, 0, 5);
    push_request(KIND_V2R, 0, INT_HI);
    push_load(1023, longint'(int'(32'hAAAA_5555)));

    run_phase(11'd0, SHAPE_ASCEND, 30, 1'b0);
    run_phase(11'd2, SHAPE_ASCEND, 40, 1'b0);
    run_phase(11'd3, SHAPE_FLAT, 40, 1'b0);
    run_phase(11'd5, SHAPE_SCRAMBLED, 30, 1'b0);
    run_phase(11'd17, SHAPE_ASCEND, 50, 1'b1);
    run_phase(11'd2047, SHAPE_ASCEND, 40, 1'b0);
    run_phase(11'd1024, SHAPE_KEEP, 40, 1'b0);
    run_phase(11'd30, SHAPE_FLAT, 30, 1'b0);
    run_phase(11'd16, SHAPE_SCRAMBLED, 30, 1'b1);
    run_phase(11'd1, SHAPE_KEEP, 20, 1'b0);
    wait_for_quiet();

    $display("Covered %0d loads, %0d value-to-rank and %0d rank-to-value queries, %0d clamped,",
             loads_taken, ranks_asked, values_asked, clamps_predicted);
    $display("%0d ignored items, %0d results checked, entry counts 0 to 2047, %0d faults.",
             ignored_taken, answers_checked, fault_count);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout: %0d transactions pending, %0d results outstanding",
             pending_requests.size(), awaited_answers.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
